@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesized
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

@@ rtl/core/ucn_pkg.sv @@
// ---------------------------------------------------------------------------
// ucn_pkg
// shared types, constants and code point functions of the normalizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ucn_pkg;

   localparam int CP_W          = 21;
   localparam int MAX_OUT_BYTES = 6;
   localparam int CNT_W         = $clog2(MAX_OUT_BYTES + 1);
   localparam int POS_W         = $clog2(MAX_OUT_BYTES);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
   localparam logic [CP_W-1:0] FW_FIRST       = 21'h00FF01;
   localparam logic [CP_W-1:0] FW_LAST        = 21'h00FF5E;
   localparam logic [CP_W-1:0] ASCII_BANG     = 21'h000021;
   localparam logic [CP_W-1:0] ASCII_UPPER_A  = 21'h000041;
   localparam logic [CP_W-1:0] ASCII_LOWER_A  = 21'h000061;
   localparam logic [CP_W-1:0] BOLD_UPPER     = 21'h01D400;
   localparam logic [CP_W-1:0] BOLD_LOWER     = 21'h01D41A;
   localparam logic [CP_W-1:0] BOLD_END       = 21'h01D434;
   localparam logic [CP_W-1:0] CP_LIMIT       = 21'h110000;
   localparam logic [CP_W-1:0] ZW_FIRST       = 21'h00200B;
   localparam logic [CP_W-1:0] ZW_LAST        = 21'h00200F;
   localparam logic [CP_W-1:0] ZW_BOM         = 21'h00FEFF;
   localparam logic [CP_W-1:0] SOFT_HYPHEN    = 21'h0000AD;
   localparam logic [CP_W-1:0] INVIS_FIRST    = 21'h002060;
   localparam logic [CP_W-1:0] INVIS_LAST     = 21'h002064;
   localparam logic [CP_W-1:0] ONE_BYTE_END   = 21'h000080;
   localparam logic [CP_W-1:0] TWO_BYTE_END   = 21'h000800;
   localparam logic [CP_W-1:0] THREE_BYTE_END = 21'h010000;

   typedef struct packed {
      logic [CP_W-1:0] cp_a;
      logic            v_a;
      logic [CP_W-1:0] cp_b;
      logic            v_b;
   } ucn_entry_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } ucn_enc_type;

   function automatic logic is_invisible(input logic [CP_W-1:0] cp);
      return (cp >= ZW_FIRST && cp <= ZW_LAST) || cp == ZW_BOM ||
             cp == SOFT_HYPHEN || (cp >= INVIS_FIRST && cp <= INVIS_LAST);
   endfunction

   // cyrillic and greek look-alikes
   function automatic logic [CP_W-1:0] lookalike(input logic [CP_W-1:0] cp);
      logic [CP_W-1:0] r;
      case (cp)
         21'h000410: r = 21'h41;
         21'h000412: r = 21'h42;
         21'h000415: r = 21'h45;
         21'h00041A: r = 21'h4B;
         21'h00041C: r = 21'h4D;
         21'h00041D: r = 21'h48;
         21'h00041E: r = 21'h4F;
         21'h000420: r = 21'h50;
         21'h000421: r = 21'h43;
         21'h000422: r = 21'h54;
         21'h000423: r = 21'h59;
         21'h000425: r = 21'h58;
         21'h000430: r = 21'h61;
         21'h000435: r = 21'h65;
         21'h00043E: r = 21'h6F;
         21'h000440: r = 21'h70;
         21'h000441: r = 21'h63;
         21'h000443: r = 21'h79;
         21'h000445: r = 21'h78;
         21'h000391: r = 21'h41;
         21'h000392: r = 21'h42;
         21'h000395: r = 21'h45;
         21'h000397: r = 21'h48;
         21'h000399: r = 21'h49;
         21'h00039A: r = 21'h4B;
         21'h00039C: r = 21'h4D;
         21'h00039D: r = 21'h4E;
         21'h00039F: r = 21'h4F;
         21'h0003A1: r = 21'h50;
         21'h0003A4: r = 21'h54;
         21'h0003A5: r = 21'h59;
         21'h0003A7: r = 21'h58;
         21'h0003B1: r = 21'h61;
         21'h0003BF: r = 21'h6F;
         default:    r = cp;
      endcase
      return r;
   endfunction

   function automatic logic [CP_W-1:0] fold_cp(input logic [CP_W-1:0] cp);
      logic [CP_W-1:0] r;
      if (cp >= FW_FIRST && cp <= FW_LAST) begin
         r = cp - FW_FIRST + ASCII_BANG;
      end else if (cp >= BOLD_UPPER && cp < BOLD_LOWER) begin
         r = cp - BOLD_UPPER + ASCII_UPPER_A;
      end else if (cp >= BOLD_LOWER && cp < BOLD_END) begin
         r = cp - BOLD_LOWER + ASCII_LOWER_A;
      end else begin
         r = lookalike(cp);
      end
      return r;
   endfunction

   // drop, fold and re-encode one code point
   function automatic ucn_enc_type encode_cp(input logic [CP_W-1:0] cp_raw);
      ucn_enc_type     e;
      logic [CP_W-1:0] cp;
      e.bytes = '0;
      e.count = 3'd0;
      cp      = fold_cp(cp_raw);
      if (!is_invisible(cp_raw)) begin
         if (cp < ONE_BYTE_END) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
         end else if (cp < TWO_BYTE_END) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count    = 3'd2;
         end else if (cp < THREE_BYTE_END) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count    = 3'd3;
         end else if (cp < CP_LIMIT) begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count    = 3'd4;
         end
      end
      return e;
   endfunction

endpackage

@@ rtl/core/utf8_confusable_normalizer.sv @@
// ---------------------------------------------------------------------------
// utf8_confusable_normalizer
// streaming utf-8 normalizer: drops zero-width characters, folds look-alike
// letters and fullwidth forms to ascii, replaces stray bytes and broken or cut-off sequences with U+FFFD
// ---------------------------------------------------------------------------
// A raw byte can be transferred in every cycle in which full is low. The
// decoder turns each byte into zero, one or two code points in the cycle it
// is taken and writes them to a four-entry queue; the encoder pulls one entry
// per cycle while its output register is empty or taking out its final byte,
// re-encodes it and hands out its bytes one per transfer, so the first result
// byte of an input byte passes through the queue and the output register.
// An input byte causes zero to six result bytes, run_last marking its final
// one. Sustained rate is set by the encoder's output register: one input byte
// per cycle while each causes at most one result byte and pop stays high;
// otherwise the entry's bytes go out first; a zero-width entry still loads.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module utf8_confusable_normalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);
   import ucn_pkg::*;

   logic          accept;
   logic          ent_valid;
   ucn_entry_type ent;
   ucn_entry_type q_head;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   ucn_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .entry_valid (ent_valid),
      .entry       (ent)
   );

   ucn_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (ent_valid),
      .din   (ent),
      .pop   (q_pop),
      .dout  (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   ucn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_entry   (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_empty (empty),
      .out_pop   (pop),
      .out_byte  (rsp_out_byte),
      .run_last  (rsp_run_last)
   );

   `ASSERT_NEVER(a_pop_from_empty_queue, clock, reset, q_pop && q_empty)
   `ASSERT_CLK(a_empty_after_reset, clock, 1'b0, reset |=> empty)
   `ASSERT_NEVER(a_entry_without_code_point, clock, reset, ent_valid && !ent.v_a)

endmodule

@@ rtl/core/ucn_front.sv @@
// ---------------------------------------------------------------------------
// ucn_front
// utf-8 decoder: gathers sequences, yields up to two code points per byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucn_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_text,
   output logic                  entry_valid,
   output ucn_pkg::ucn_entry_type entry
);
   import ucn_pkg::*;

   logic [CP_W-1:0] pcp_ff, pcp_in;
   logic [1:0]      due_ff, due_in;
   logic            brk;
   logic            lead_emit;
   logic [CP_W-1:0] lead_cp;

   always_comb begin
      pcp_in    = pcp_ff;
      due_in    = due_ff;
      entry     = '0;
      brk       = 1'b0;
      lead_emit = 1'b0;
      lead_cp   = REPLACEMENT_CP;
      if (due_ff != 2'd0 && in_byte[7:6] == 2'b10) begin
         pcp_in = {pcp_ff[CP_W-7:0], in_byte[5:0]};
         due_in = due_ff - 2'd1;
         if (due_in == 2'd0) begin
            entry.cp_a = pcp_in;
            entry.v_a  = 1'b1;
         end
      end else begin
         brk    = (due_ff != 2'd0);
         due_in = 2'd0;
         if (!in_byte[7]) begin
            lead_emit = 1'b1;
            lead_cp   = {13'd0, in_byte};
         end else if (in_byte[7:5] == 3'b110) begin
            pcp_in = {16'd0, in_byte[4:0]};
            due_in = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            pcp_in = {17'd0, in_byte[3:0]};
            due_in = 2'd2;
         end else if (in_byte[7:3] == 5'b11110) begin
            pcp_in = {18'd0, in_byte[2:0]};
            due_in = 2'd3;
         end else begin
            lead_emit = 1'b1;
         end
         if (brk) begin
            entry.cp_a = REPLACEMENT_CP;
            entry.v_a  = 1'b1;
            entry.cp_b = lead_cp;
            entry.v_b  = lead_emit;
         end else begin
            entry.cp_a = lead_cp;
            entry.v_a  = lead_emit;
         end
      end
      // cut-off sequence at end of text
      if (end_of_text && due_in != 2'd0) begin
         due_in = 2'd0;
         if (entry.v_a) begin
            entry.cp_b = REPLACEMENT_CP;
            entry.v_b  = 1'b1;
         end else begin
            entry.cp_a = REPLACEMENT_CP;
            entry.v_a  = 1'b1;
         end
      end
   end

   assign entry_valid = accept && (entry.v_a || entry.v_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         pcp_ff <= '0;
         due_ff <= 2'd0;
      end else if (accept) begin
         pcp_ff <= pcp_in;
         due_ff <= due_in;
      end
   end

endmodule

@@ rtl/core/ucn_queue.sv @@
// ---------------------------------------------------------------------------
// ucn_queue
// short first-in first-out queue of decoded entries
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucn_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ucn_pkg::ucn_entry_type din,
   input  logic                   pop,
   output ucn_pkg::ucn_entry_type dout,
   output logic                   full,
   output logic                   empty
);
   import ucn_pkg::*;

   ucn_entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in;
   logic [QPTR_W-1:0]       rd_ff, rd_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign full    = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

@@ rtl/core/ucn_back.sv @@
// ---------------------------------------------------------------------------
// ucn_back
// folds and re-encodes code points, sends result bytes one per transfer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucn_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ucn_pkg::ucn_entry_type q_entry,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   out_empty,
   input  logic                   out_pop,
   output logic [7:0]             out_byte,
   output logic                   run_last
);
   import ucn_pkg::*;

   ucn_enc_type                      enc_a, enc_b;
   logic [2:0]                       ka, kb;
   logic [MAX_OUT_BYTES-1:0][7:0]    merged;
   logic [2:0]                       j;
   logic [CNT_W-1:0]                 total;
   logic [MAX_OUT_BYTES-1:0][7:0]    buf_ff, buf_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [POS_W-1:0]                 pos_ff, pos_in;
   logic                             last;
   logic                             take;

   always_comb begin
      enc_a  = encode_cp(q_entry.cp_a);
      enc_b  = encode_cp(q_entry.cp_b);
      ka     = q_entry.v_a ? enc_a.count : 3'd0;
      kb     = q_entry.v_b ? enc_b.count : 3'd0;
      total  = CNT_W'(ka + kb);
      merged = '0;
      j      = '0;
      for (int i = 0; i < MAX_OUT_BYTES; i++) begin
         j = 3'(i) - ka;
         if (3'(i) < ka) begin
            merged[i] = enc_a.bytes[2'(i)];
         end else if (j < kb) begin
            merged[i] = enc_b.bytes[j[1:0]];
         end
      end
   end

   assign out_empty = (cnt_ff == '0);
   assign last      = (CNT_W'(pos_ff) == cnt_ff - 1'b1);
   assign take      = !out_empty && out_pop;
   assign q_pop     = !q_empty && (out_empty || (take && last));
   assign out_byte  = buf_ff[pos_ff];
   assign run_last  = last;

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      if (q_pop) begin
         buf_in = merged;
         cnt_in = total;
         pos_in = '0;
      end else if (take && last) begin
         cnt_in = '0;
         pos_in = '0;
      end else if (take) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

@@ bench/utf8_confusable_normalizer_tb.sv @@
// ---------------------------------------------------------------------------
// utf8_confusable_normalizer_tb
// Drives UTF-8 bytes into the normalizer and predicts every output byte:
// zero-width characters vanish, look-alike and fullwidth letters become
// ASCII, and stray bytes and broken or cut-off sequences turn into U+FFFD. A short
// directed text comes first, then random code points (mostly well formed,
// some overlong, out of range, truncated or plain noise) under several mixes
// of sender gaps and receiver stalls, including a long output hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

localparam int TWIN_N = 34;
localparam logic [20:0] TWIN_CP [TWIN_N] = '{
   21'h0410, 21'h0412, 21'h0415, 21'h041A, 21'h041C, 21'h041D, 21'h041E,
   21'h0420, 21'h0421, 21'h0422, 21'h0423, 21'h0425, 21'h0430, 21'h0435,
   21'h043E, 21'h0440, 21'h0441, 21'h0443, 21'h0445, 21'h0391, 21'h0392,
   21'h0395, 21'h0397, 21'h0399, 21'h039A, 21'h039C, 21'h039D, 21'h039F,
   21'h03A1, 21'h03A4, 21'h03A5, 21'h03A7, 21'h03B1, 21'h03BF};
localparam logic [7:0] TWIN_CH [TWIN_N] = '{
   8'h41, 8'h42, 8'h45, 8'h4B, 8'h4D, 8'h48, 8'h4F,
   8'h50, 8'h43, 8'h54, 8'h59, 8'h58, 8'h61, 8'h65,
   8'h6F, 8'h70, 8'h63, 8'h79, 8'h78, 8'h41, 8'h42,
   8'h45, 8'h48, 8'h49, 8'h4B, 8'h4D, 8'h4E, 8'h4F,
   8'h50, 8'h54, 8'h59, 8'h58, 8'h61, 8'h6F};

localparam logic [20:0] REPL_CP = 21'h00FFFD;

typedef struct {
   logic [7:0] out_byte;
   logic       run_last;
} out_byte_type;

class utf8_fold_checker;
   out_byte_type due_bytes[$];
   out_byte_type run_bytes[$];
   logic [20:0]  cp_acc;
   logic [1:0]   cont_left;
   int           mismatches;
   int           checked;
   int           repl_count;
   int           dropped;

   function new();
      cp_acc     = '0;
      cont_left  = '0;
      mismatches = 0;
      checked    = 0;
      repl_count = 0;
      dropped    = 0;
   endfunction

   task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
   endtask

   function bit zero_width(logic [20:0] cp);
      return (cp >= 21'h200B && cp <= 21'h200F) || cp == 21'hFEFF ||
             cp == 21'h00AD || (cp >= 21'h2060 && cp <= 21'h2064);
   endfunction

   function logic [20:0] ascii_fold(logic [20:0] cp);
      if (cp >= 21'hFF01 && cp <= 21'hFF5E) return cp - 21'hFF01 + 21'h21;
      if (cp >= 21'h1D400 && cp < 21'h1D41A) return cp - 21'h1D400 + 21'h41;
      if (cp >= 21'h1D41A && cp < 21'h1D434) return cp - 21'h1D41A + 21'h61;
      foreach (TWIN_CP[i]) if (TWIN_CP[i] == cp) return {13'd0, TWIN_CH[i]};
      return cp;
   endfunction

   function void put(logic [7:0] b);
      out_byte_type w;
      w.out_byte = b;
      w.run_last = 1'b0;
      run_bytes.insert(run_bytes.size(), w);
   endfunction

   function void emit_cp(logic [20:0] raw);
      logic [20:0] c;
      if (raw == REPL_CP) repl_count++;
      if (zero_width(raw)) begin
         dropped++;
         return;
      end
      c = ascii_fold(raw);
      if (c < 21'h80) begin
         put(c[7:0]);
      end else if (c < 21'h800) begin
         put({3'b110, c[10:6]});
         put({2'b10, c[5:0]});
      end else if (c < 21'h10000) begin
         put({4'b1110, c[15:12]});
         put({2'b10, c[11:6]});
         put({2'b10, c[5:0]});
      end else if (c < 21'h110000) begin
         put({5'b11110, c[20:18]});
         put({2'b10, c[17:12]});
         put({2'b10, c[11:6]});
         put({2'b10, c[5:0]});
      end
   endfunction

   function void open_lead(logic [7:0] b);
      if (b[7] == 1'b0) begin
         emit_cp({13'd0, b});
      end else if (b[7:5] == 3'b110) begin
         cp_acc    = {16'd0, b[4:0]};
         cont_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         cp_acc    = {17'd0, b[3:0]};
         cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         cp_acc    = {18'd0, b[2:0]};
         cont_left = 2'd3;
      end else begin
         emit_cp(REPL_CP);
      end
   endfunction

   // one accepted input byte: predict the output bytes it causes
   function void take_in_byte(logic [7:0] b, logic eot);
      run_bytes.delete();
      if (cont_left != 0) begin
         if (b[7:6] == 2'b10) begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) emit_cp(cp_acc);
         end else begin
            cont_left = 2'd0;
            emit_cp(REPL_CP);
            open_lead(b);
         end
      end else begin
         open_lead(b);
      end
      if (eot && cont_left != 0) begin
         cont_left = 2'd0;
         emit_cp(REPL_CP);
      end
      foreach (run_bytes[i]) begin
         run_bytes[i].run_last = (i == run_bytes.size() - 1);
         due_bytes.insert(due_bytes.size(), run_bytes[i]);
      end
   endfunction

   task match_out_byte(logic [7:0] got_byte, logic got_last);
      out_byte_type w;
      checked++;
      if (due_bytes.size() == 0) begin
         report($sformatf("unexpected output byte %02h last=%0b", got_byte, got_last));
         return;
      end
      w = due_bytes.pop_front();
      if (got_byte !== w.out_byte)
         report($sformatf("byte %0d out_byte got %02h expected %02h",
                          checked, got_byte, w.out_byte));
      if (got_last !== w.run_last)
         report($sformatf("byte %0d run_last got %0b expected %0b",
                          checked, got_last, w.run_last));
   endtask

   function int waiting();
      return due_bytes.size();
   endfunction
endclass

module utf8_confusable_normalizer_tb;

   localparam int LIMIT = 300000;
   localparam int DIRECTED_N = 27;

   // {end_of_text, byte}
   localparam logic [8:0] DIRECTED [DIRECTED_N] = '{
      9'h000, 9'h17F, 9'h080, 9'h0FF,
      9'h0C3, 9'h041,
      9'h0E2, 9'h080, 9'h08B,
      9'h0EF, 9'h0BC, 9'h081,
      9'h0F0, 9'h09D, 9'h090, 9'h09A,
      9'h0D0, 9'h090,
      9'h0E2, 9'h0F8,
      9'h0F4, 9'h090, 9'h080, 9'h080,
      9'h0E2, 9'h080, 9'h1F0};

   localparam int NEAR_N = 20;
   localparam logic [20:0] NEAR_ZW [NEAR_N] = '{
      21'h00AC, 21'h00AD, 21'h00AE, 21'h200A, 21'h200B, 21'h200C, 21'h200D,
      21'h200E, 21'h200F, 21'h2010, 21'h205F, 21'h2060, 21'h2061, 21'h2062,
      21'h2063, 21'h2064, 21'h2065, 21'hFEFE, 21'hFEFF, 21'hFF00};

   logic       clock = 1'b0;
   logic       reset;
   logic       push;
   logic       full;
   logic [7:0] req_in_byte;
   logic       req_end_of_text;
   logic       empty;
   logic       pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   utf8_fold_checker board = new();
   int  send_idle_pct = 0;
   int  pop_stall_pct = 0;
   int  hold_requests = 0;
   int  bytes_sent    = 0;
   int  cycle_count   = 0;

   utf8_confusable_normalizer u_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) board.match_out_byte(rsp_out_byte, rsp_run_last);
   end

   // receiver side, including the long hold when asked for
   initial begin : receiver
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_seen) begin
            hold_left  = 120;
            holds_seen = hold_requests;
         end
         if (reset || hold_left > 0) begin
            pop <= 1'b0;
            if (hold_left > 0) hold_left--;
         end else begin
            pop <= ($urandom_range(99) >= pop_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eot);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         push        <= 1'b0;
         req_in_byte <= 8'($urandom);
         @(negedge clock);
      end
      push            <= 1'b1;
      req_in_byte     <= b;
      req_end_of_text <= eot;
      @(posedge clock);
      while (full) @(posedge clock);
      board.take_in_byte(b, eot);
      bytes_sent++;
   endtask

   task automatic sender_quiet();
      @(negedge clock);
      push <= 1'b0;
   endtask

   task automatic wait_results();
      while (board.waiting() != 0) @(posedge clock);
   endtask

   // the first keep bytes of the len-byte form of cp
   task automatic send_seq(input logic [20:0] cp, input int len, input int keep,
                           input bit eot_end);
      logic [7:0] b;
      for (int k = 0; k < keep; k++) begin
         if (k == 0) begin
            case (len)
               1: b = {1'b0, cp[6:0]};
               2: b = {3'b110, cp[10:6]};
               3: b = {4'b1110, cp[15:12]};
               default: b = {5'b11110, cp[20:18]};
            endcase
         end else begin
            b = {2'b10, 6'(cp >> (6 * (len - 1 - k)))};
         end
         send_byte(b, eot_end && k == keep - 1);
      end
   endtask

   function automatic int cp_len(logic [20:0] cp);
      if (cp < 21'h80) return 1;
      if (cp < 21'h800) return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   function automatic logic [20:0] pick_cp();
      logic [20:0] cp;
      int          t;
      t = $urandom_range(9);
      case (t)
         0, 1: cp = 21'($urandom_range(21'h7F));
         2:    cp = 21'($urandom_range(21'h7FF, 21'h80));
         3:    cp = 21'($urandom_range(21'hFFFF, 21'h800));
         4:    cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
         5:    cp = NEAR_ZW[$urandom_range(NEAR_N - 1)];
         6:    cp = 21'($urandom_range(21'hFF5F, 21'hFF00));
         7:    cp = 21'($urandom_range(21'h1D434, 21'h1D3FF));
         8:    cp = TWIN_CP[$urandom_range(TWIN_N - 1)] + ($urandom_range(3) == 0);
         default: cp = ($urandom_range(1) == 0) ? REPL_CP :
                       21'($urandom_range(21'hDFFF, 21'hD800));
      endcase
      return cp;
   endfunction

   task automatic send_piece();
      logic [20:0] cp;
      int          kind;
      int          len;
      kind = $urandom_range(99);
      cp   = pick_cp();
      len  = cp_len(cp);
      if (kind < 62) begin
         send_seq(cp, len, len, $urandom_range(19) == 0);
      end else if (kind < 72) begin
         // overlong form, or a four byte form beyond the code space
         if (len < 4 && $urandom_range(1) == 0)
            send_seq(cp, $urandom_range(4, len + 1), $urandom_range(4, len + 1) > 0 ?
                     0 : 0, 1'b0);
         if (len < 4) begin
            len = $urandom_range(4, len + 1);
            send_seq(cp, len, len, 1'b0);
         end else begin
            cp = 21'($urandom_range(21'h1FFFFF, 21'h110000));
            send_seq(cp, 4, 4, 1'b0);
         end
      end else if (kind < 86 && len > 1) begin
         send_seq(cp, len, $urandom_range(len - 1, 1), $urandom_range(1) == 0);
      end else begin
         send_byte(8'($urandom), $urandom_range(9) == 0);
      end
   endtask

   task automatic run_text(input int n);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n) send_piece();
   endtask

   initial begin
      reset           = 1'b1;
      push            = 1'b0;
      req_in_byte     = 8'h00;
      req_end_of_text = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      sender_quiet();
      wait_results();

      run_text(80);

      // hold the output side while input keeps coming
      hold_requests++;
      run_text(40);

      send_idle_pct = 85;
      run_text(60);
      sender_quiet();
      wait_results();

      send_idle_pct = 0;
      pop_stall_pct = 85;
      run_text(60);

      send_idle_pct = 18;
      pop_stall_pct = 18;
      run_text(80);

      sender_quiet();
      wait_results();
      repeat (16) @(posedge clock);

      $display("covered %0d input bytes under four idle mixes and a long output hold",
               bytes_sent);
      $display("%0d output bytes checked, %0d U+FFFD predicted, %0d zero-width dropped",
               board.checked, board.repl_count, board.dropped);
      if (board.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ utf8_confusable_normalizer.f @@
+incdir+rtl/core
rtl/core/ucn_pkg.sv
rtl/core/ucn_front.sv
rtl/core/ucn_queue.sv
rtl/core/ucn_back.sv
rtl/core/utf8_confusable_normalizer.sv
bench/utf8_confusable_normalizer_tb.sv
